FILE: src/nec_ir_frame_transmitter_top_macros.svh
// ----------------------------------------------------------------------------
// NEC IR frame transmitter assertion macros
// Shared concurrent property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef NEC_IR_FRAME_TRANSMITTER_TOP_MACROS_SVH
`define NEC_IR_FRAME_TRANSMITTER_TOP_MACROS_SVH

// same-cycle implication
`define NIRT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NIRT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/nirt_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR frame transmitter package
// Widths, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
package nirt_pkg;

    localparam int DurW      = 10;
    localparam int TickW     = 11;
    localparam int SegW      = 7;
    localparam int CodeW     = 16;
    localparam int ByteW     = 8;
    localparam int CfgIdxW   = 3;

    localparam logic [SegW-1:0] SegCount     = 7'd69;
    localparam logic [SegW-1:0] SegLeadMark  = 7'd0;
    localparam logic [SegW-1:0] SegLeadSpace = 7'd1;
    localparam logic [SegW-1:0] SegBitFirst  = 7'd2;
    localparam logic [SegW-1:0] SegBitLast   = 7'd65;
    localparam logic [SegW-1:0] SegTrlMark   = 7'd66;
    localparam logic [SegW-1:0] SegRptSpace  = 7'd67;
    localparam logic [SegW-1:0] SegEndMark   = 7'd68;

    localparam logic [DurW-1:0] LeaderMarkRst  = 10'd342;
    localparam logic [DurW-1:0] LeaderSpaceRst = 10'd171;
    localparam logic [DurW-1:0] BitMarkRst     = 10'd21;
    localparam logic [DurW-1:0] OneSpaceRst    = 10'd64;
    localparam logic [DurW-1:0] ZeroSpaceRst   = 10'd21;
    localparam logic [DurW-1:0] RepeatSpaceRst = 10'd85;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_LEADER_MARK  = 3'd0,
        CFG_LEADER_SPACE = 3'd1,
        CFG_BIT_MARK     = 3'd2,
        CFG_ONE_SPACE    = 3'd3,
        CFG_ZERO_SPACE   = 3'd4,
        CFG_REPEAT_SPACE = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [DurW-1:0] leader_mark;
        logic [DurW-1:0] leader_space;
        logic [DurW-1:0] bit_mark;
        logic [DurW-1:0] one_space;
        logic [DurW-1:0] zero_space;
        logic [DurW-1:0] repeat_space;
    } cfg_regs_t;

    typedef struct packed {
        logic carrier_gate;
        logic carrier_phase;
        logic busy_res;
        logic frame_done;
    } result_t;

endpackage

FILE: src/nec_ir_frame_transmitter_top.sv
// An accepted result is registered in the output register or the skid stage.
// Throughput: one request per cycle; an output register plus a skid stage
// keep s_ready high while one result waits, so it drops only with two held.
// Reset (aresetn low, synchronous): frame idle, timing registers to defaults.
// ----------------------------------------------------------------------------
// NEC IR frame transmitter top level
// Configuration registers, frame sequencer and output buffering.
// ----------------------------------------------------------------------------
module nec_ir_frame_transmitter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [nirt_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [nirt_pkg::DurW-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [nirt_pkg::CodeW-1:0]        s_custom_code,
    input  logic [nirt_pkg::ByteW-1:0]        s_data_byte,
    input  logic                              s_checksum_mode,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_carrier_gate,
    output logic                              m_carrier_phase,
    output logic                              m_busy_res,
    output logic                              m_frame_done
);
    import nirt_pkg::*;

    cfg_regs_t cfg_reg;
    result_t   res;
    result_t   out_reg,  out_next;
    result_t   skid_reg, skid_next;
    logic      out_valid_reg,  out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    logic      s_acc, m_acc;

    assign s_ready = !skid_valid_reg;
    assign s_acc   = s_valid && s_ready;
    assign m_acc   = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.leader_mark  <= LeaderMarkRst;
            cfg_reg.leader_space <= LeaderSpaceRst;
            cfg_reg.bit_mark     <= BitMarkRst;
            cfg_reg.one_space    <= OneSpaceRst;
            cfg_reg.zero_space   <= ZeroSpaceRst;
            cfg_reg.repeat_space <= RepeatSpaceRst;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_LEADER_MARK:  cfg_reg.leader_mark  <= cfg_wdata;
                CFG_LEADER_SPACE: cfg_reg.leader_space <= cfg_wdata;
                CFG_BIT_MARK:     cfg_reg.bit_mark     <= cfg_wdata;
                CFG_ONE_SPACE:    cfg_reg.one_space    <= cfg_wdata;
                CFG_ZERO_SPACE:   cfg_reg.zero_space   <= cfg_wdata;
                CFG_REPEAT_SPACE: cfg_reg.repeat_space <= cfg_wdata;
                default: ;
            endcase
        end
    end

    nirt_frame_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (s_acc),
        .command       (s_command),
        .custom_code   (s_custom_code),
        .data_byte     (s_data_byte),
        .checksum_mode (s_checksum_mode),
        .cfg           (cfg_reg),
        .res           (res)
    );

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (m_acc) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else if (s_acc) begin
                out_next = res;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (s_acc) begin
            if (out_valid_reg) begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end else begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_carrier_gate  = out_reg.carrier_gate;
    assign m_carrier_phase = out_reg.carrier_phase;
    assign m_busy_res      = out_reg.busy_res;
    assign m_frame_done    = out_reg.frame_done;

endmodule

FILE: src/nirt_frame_seq.sv
// ----------------------------------------------------------------------------
// NEC IR frame sequencer
// Holds the frame state and computes the result of one request.
// ----------------------------------------------------------------------------
module nirt_frame_seq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step_en,
    input  logic                              command,
    input  logic [nirt_pkg::CodeW-1:0]        custom_code,
    input  logic [nirt_pkg::ByteW-1:0]        data_byte,
    input  logic                              checksum_mode,
    input  nirt_pkg::cfg_regs_t               cfg,
    output nirt_pkg::result_t                 res
);
    import nirt_pkg::*;

    logic [CodeW-1:0] code_word_reg, code_word_next;
    logic [CodeW-1:0] data_word_reg, data_word_next;
    logic [SegW-1:0]  seg_idx_reg,   seg_idx_next;
    logic [TickW-1:0] tick_cnt_reg,  tick_cnt_next;
    logic             gate_on_reg,   gate_on_next;
    logic             phase_reg,     phase_next;
    logic             sending_reg,   sending_next;

    logic [SegW-1:0]   bit_off;
    logic [4:0]        bit_sel;
    logic [2*CodeW-1:0] bit_word;
    logic [DurW-1:0]   dur;
    logic [TickW-1:0]  limit;
    logic [ByteW-1:0]  byte_sel;
    logic [SegW-1:0]   seg_inc;
    logic              done;

    assign bit_off  = seg_idx_reg - SegBitFirst;
    assign bit_sel  = bit_off[5:1];
    assign bit_word = {data_word_reg, code_word_reg};

    always_comb begin
        dur = '0;
        if (seg_idx_reg == SegLeadMark || seg_idx_reg == SegTrlMark) begin
            dur = cfg.leader_mark;
        end else if (seg_idx_reg == SegLeadSpace) begin
            dur = cfg.leader_space;
        end else if (seg_idx_reg >= SegBitFirst && seg_idx_reg <= SegBitLast) begin
            if (!bit_off[0]) begin
                dur = cfg.bit_mark;
            end else if (bit_word[bit_sel]) begin
                dur = cfg.one_space;
            end else begin
                dur = cfg.zero_space;
            end
        end else if (seg_idx_reg == SegRptSpace) begin
            dur = cfg.repeat_space;
        end else if (seg_idx_reg == SegEndMark) begin
            dur = cfg.bit_mark;
        end
    end

    assign limit   = {dur, 1'b0};
    assign seg_inc = seg_idx_reg + 7'd1;
    assign byte_sel = checksum_mode ?
        ~(custom_code[15:8] + custom_code[7:0]) : data_byte;

    always_comb begin
        code_word_next = code_word_reg;
        data_word_next = data_word_reg;
        seg_idx_next   = seg_idx_reg;
        tick_cnt_next  = tick_cnt_reg;
        gate_on_next   = gate_on_reg;
        phase_next     = phase_reg;
        sending_next   = sending_reg;
        done           = 1'b0;
        if (command) begin
            code_word_next = custom_code;
            data_word_next = {~byte_sel, byte_sel};
            seg_idx_next   = '0;
            tick_cnt_next  = '0;
            gate_on_next   = 1'b1;
            sending_next   = 1'b1;
        end else if (sending_reg) begin
            phase_next = ~phase_reg;
            if (tick_cnt_reg != limit) begin
                tick_cnt_next = tick_cnt_reg + 11'd1;
            end else begin
                tick_cnt_next = '0;
                seg_idx_next  = seg_inc;
                gate_on_next  = ~seg_inc[0];
                if (seg_inc >= SegCount) begin
                    gate_on_next = 1'b0;
                    sending_next = 1'b0;
                    done         = 1'b1;
                end
            end
        end
        res.carrier_gate  = gate_on_next;
        res.carrier_phase = phase_next;
        res.busy_res      = sending_next;
        res.frame_done    = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_word_reg <= '0;
            data_word_reg <= '0;
            seg_idx_reg   <= '0;
            tick_cnt_reg  <= '0;
            gate_on_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            sending_reg   <= 1'b0;
        end else if (step_en) begin
            code_word_reg <= code_word_next;
            data_word_reg <= data_word_next;
            seg_idx_reg   <= seg_idx_next;
            tick_cnt_reg  <= tick_cnt_next;
            gate_on_reg   <= gate_on_next;
            phase_reg     <= phase_next;
            sending_reg   <= sending_next;
        end
    end

endmodule

FILE: src/nirt_checker.sv
// ----------------------------------------------------------------------------
// NEC IR frame transmitter checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "nec_ir_frame_transmitter_top_macros.svh"

module nirt_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_carrier_gate,
    input logic m_carrier_phase,
    input logic m_busy_res,
    input logic m_frame_done
);

    `NIRT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_carrier_gate) && $stable(m_carrier_phase) && $stable(m_busy_res) && $stable(m_frame_done), "result changed while stalled")
    `NIRT_ASSERT_NOW(a_done_idle, aclk, aresetn, m_valid && m_frame_done, !m_busy_res && !m_carrier_gate, "frame end while still busy or gated")
    `NIRT_ASSERT_NOW(a_idle_gate, aclk, aresetn, m_valid && !m_busy_res, !m_carrier_gate, "carrier gated while idle")
    `NIRT_ASSERT_NOW(a_stall_full, aclk, aresetn, !s_ready, m_valid, "input stalled with no result pending")

endmodule

bind nec_ir_frame_transmitter_top nirt_checker u_nirt_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_carrier_gate  (m_carrier_gate),
    .m_carrier_phase (m_carrier_phase),
    .m_busy_res      (m_busy_res),
    .m_frame_done    (m_frame_done)
);
